### hdl/mcfir_pkg.sv
// Shared constants, types and the coefficient table of the multichannel FIR high-pass unit.
// Used by the interfaces, the controller, the datapath, the top level and the checker.
`default_nettype none

package mcfir_pkg;

   localparam int CHANNELS     = 8;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_WIDTH   = 16;
   localparam int CHAN_WIDTH   = 3;
   localparam int TAPS         = 47;
   localparam int HALF_TAPS    = 24;

   localparam int PTR_WIDTH  = $clog2(TAPS);
   localparam int FILL_WIDTH = $clog2(TAPS + 1);
   localparam int HALF_WIDTH = $clog2(HALF_TAPS);
   localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + $clog2(TAPS);
   localparam int ADDR_WIDTH = CHAN_WIDTH + PTR_WIDTH;
   localparam int MEM_DEPTH  = 2 ** ADDR_WIDTH;
   localparam int NUM_SLOTS  = 2 ** CHAN_WIDTH;

   // First half of the symmetric impulse response in Q1.15; the last entry is the center tap.
   localparam int COEF_Q15 [HALF_TAPS] = '{
      -309, 259, 207, 158, 80, -35, -174, -300,
      -368, -334, -176, 94, 427, 737, 919, 870,
      518, -158, -1115, -2244, -3388, -4374, -5040, 27492
   };

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_MAC   = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   typedef struct packed {
      logic                 load;
      logic                 issue;
      logic                 finish;
      logic [PTR_WIDTH-1:0] tap;
   } cmd_type;

   typedef struct packed {
      logic pipe_empty;
      logic out_busy;
   } status_type;

   function automatic logic signed [COEF_WIDTH-1:0] coef_at(input logic [PTR_WIDTH-1:0] k);
      logic [HALF_WIDTH-1:0] idx;
      int                    c;
      idx = (int'(k) < HALF_TAPS) ? HALF_WIDTH'(k) : HALF_WIDTH'(TAPS - 1 - int'(k));
      c = COEF_Q15[idx];
      if (COEF_WIDTH >= 16) begin
         c = c <<< (COEF_WIDTH - 16);
      end else begin
         c = (c + (1 <<< (15 - COEF_WIDTH))) >>> (16 - COEF_WIDTH);
      end
      return COEF_WIDTH'(c);
   endfunction

endpackage

`default_nettype wire

### hdl/mcfir_req_if.sv
// Input channel of the FIR unit: valid, ready and one sample word with its channel number.
// Depends on mcfir_pkg for the field widths.
`default_nettype none

interface mcfir_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] sample_in;
   logic [mcfir_pkg::CHAN_WIDTH-1:0]          chan_in;

   modport source (output valid, output sample_in, output chan_in, input ready);
   modport sink   (input valid, input sample_in, input chan_in, output ready);
endinterface

`default_nettype wire

### hdl/mcfir_rsp_if.sv
// Result channel of the FIR unit: valid, ready and one filtered word with its channel number.
// Depends on mcfir_pkg for the field widths.
`default_nettype none

interface mcfir_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] sample_out;
   logic [mcfir_pkg::CHAN_WIDTH-1:0]          chan_out;

   modport source (output valid, output sample_out, output chan_out, input ready);
   modport sink   (input valid, input sample_out, input chan_out, output ready);
endinterface

`default_nettype wire

### hdl/mcfir_ctrl.sv
// Controller of the FIR unit: accepts a word, steps the tap counter, waits for the MAC pipeline and output register.
// Depends on mcfir_pkg for the state, command and status types.
`default_nettype none

module mcfir_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire mcfir_pkg::status_type status,
   output mcfir_pkg::cmd_type        cmd
);

   mcfir_pkg::state_type                state_ff, state_in;
   logic [mcfir_pkg::PTR_WIDTH-1:0]     tap_ff, tap_in;

   always_comb begin
      state_in   = state_ff;
      tap_in     = tap_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.tap    = tap_ff;
      case (state_ff)
         mcfir_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               tap_in   = '0;
               state_in = mcfir_pkg::ST_MAC;
            end
         end
         mcfir_pkg::ST_MAC: begin
            cmd.issue = 1'b1;
            if (tap_ff == mcfir_pkg::PTR_WIDTH'(mcfir_pkg::TAPS - 1)) begin
               state_in = mcfir_pkg::ST_FLUSH;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         mcfir_pkg::ST_FLUSH: begin
            if (status.pipe_empty && !status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = mcfir_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mcfir_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcfir_pkg::ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

endmodule

`default_nettype wire

### hdl/mcfir_dp.sv
// Datapath of the FIR unit: history memory, per-channel pointers, MAC pipeline and output register.
// Depends on mcfir_pkg for widths, the coefficient function and the command and status types.
`default_nettype none

module mcfir_dp (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire mcfir_pkg::cmd_type                        cmd,
   output mcfir_pkg::status_type                          status,
   input  wire logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  wire logic [mcfir_pkg::CHAN_WIDTH-1:0]          req_chan,
   input  wire logic                                      rsp_ready,
   output logic                                           rsp_valid,
   output logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0]      rsp_sample,
   output logic [mcfir_pkg::CHAN_WIDTH-1:0]               rsp_chan
);

   localparam int SW = mcfir_pkg::SAMPLE_WIDTH;
   localparam int AW = mcfir_pkg::ACC_WIDTH;
   localparam int PW = mcfir_pkg::PTR_WIDTH;
   localparam int FW = mcfir_pkg::FILL_WIDTH;

   localparam logic signed [AW-1:0] SAT_MAX = {{(AW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
   localparam logic signed [AW-1:0] SAT_MIN = ~SAT_MAX;
   localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) <<< (mcfir_pkg::COEF_WIDTH - 2);

   logic signed [SW-1:0]                   mem [mcfir_pkg::MEM_DEPTH];

   logic [PW-1:0]                          wptr_ff [mcfir_pkg::NUM_SLOTS];
   logic [FW-1:0]                          fill_ff [mcfir_pkg::NUM_SLOTS];

   logic signed [SW-1:0]                   sample_ff;
   logic [mcfir_pkg::CHAN_WIDTH-1:0]       chan_ff;
   logic                                   chan_ok_ff;
   logic [PW-1:0]                          rptr_ff;
   logic [FW-1:0]                          fill_cur_ff;

   logic signed [SW-1:0]                   rd_data_ff;
   logic                                   tap_valid_ff;
   logic signed [mcfir_pkg::COEF_WIDTH-1:0] coef_ff;
   logic                                   stage1_valid_ff;
   logic signed [mcfir_pkg::PROD_WIDTH-1:0] prod_ff;
   logic                                   prod_valid_ff;
   logic signed [AW-1:0]                   acc_ff;

   logic                                   rsp_valid_ff;
   logic signed [SW-1:0]                   rsp_sample_ff;
   logic [mcfir_pkg::CHAN_WIDTH-1:0]       rsp_chan_ff;

   logic                                   chan_ok_in;
   logic [PW-1:0]                          rptr_in;
   logic [PW-1:0]                          wptr_cur;
   logic [PW-1:0]                          wptr_in;
   logic [FW-1:0]                          fill_in;
   logic                                   tap_valid_in;
   logic signed [SW-1:0]                   operand;
   logic signed [AW-1:0]                   rounded;
   logic signed [AW-1:0]                   shifted;
   logic signed [SW-1:0]                   sat_value;

   assign chan_ok_in   = int'(req_chan) < mcfir_pkg::CHANNELS;
   assign rptr_in      = (rptr_ff == PW'(mcfir_pkg::TAPS - 1)) ? '0 : rptr_ff + 1'b1;
   assign wptr_cur     = wptr_ff[chan_ff];
   assign wptr_in      = (wptr_cur == PW'(mcfir_pkg::TAPS - 1)) ? '0 : wptr_cur + 1'b1;
   assign fill_in      = (fill_ff[chan_ff] == FW'(mcfir_pkg::TAPS)) ?
                         fill_ff[chan_ff] : fill_ff[chan_ff] + 1'b1;
   // Only the newest entries of a line that has not yet been filled hold samples.
   assign tap_valid_in = ({1'b0, cmd.tap} + {1'b0, fill_cur_ff}) >= (PW + 1)'(mcfir_pkg::TAPS);
   assign operand      = tap_valid_ff ? rd_data_ff : '0;

   always_comb begin
      rounded = acc_ff + ROUND_HALF;
      shifted = rounded >>> (mcfir_pkg::COEF_WIDTH - 1);
      if (shifted > SAT_MAX) begin
         sat_value = SW'(SAT_MAX);
      end else if (shifted < SAT_MIN) begin
         sat_value = SW'(SAT_MIN);
      end else begin
         sat_value = SW'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_data_ff <= mem[{chan_ff, rptr_ff}];
      end
      if (cmd.finish && chan_ok_ff) begin
         mem[{chan_ff, wptr_cur}] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mcfir_pkg::NUM_SLOTS; i++) begin
            wptr_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else if (cmd.finish && chan_ok_ff) begin
         wptr_ff[chan_ff] <= wptr_in;
         fill_ff[chan_ff] <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff   <= req_sample;
         chan_ff     <= req_chan;
         chan_ok_ff  <= chan_ok_in;
         rptr_ff     <= wptr_ff[req_chan];
         fill_cur_ff <= chan_ok_in ? fill_ff[req_chan] : '0;
      end else if (cmd.issue) begin
         rptr_ff <= rptr_in;
      end
      if (cmd.issue) begin
         tap_valid_ff <= tap_valid_in;
         coef_ff      <= mcfir_pkg::coef_at(cmd.tap);
      end
      prod_ff <= coef_ff * operand;
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_ff + AW'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_valid_ff <= 1'b0;
         prod_valid_ff   <= 1'b0;
      end else begin
         stage1_valid_ff <= cmd.issue;
         prod_valid_ff   <= stage1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_sample_ff <= chan_ok_ff ? sat_value : '0;
         rsp_chan_ff   <= chan_ff;
      end
   end

   assign status.pipe_empty = !stage1_valid_ff && !prod_valid_ff;
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_chan   = rsp_chan_ff;

endmodule

`default_nettype wire

### hdl/multichannel_fir_highpass_unit.sv
// Flow: one word at a time; after the accept cycle come 47 multiply-accumulate steps
// (one history memory read per tap) and a drain of the read, multiply and add stages.
// The result is then held in an output register that lets the next word be accepted while
// it waits; the next word's drain waits until that register has been taken.
// Reset: synchronous; clears the per-channel write pointers and fill counts, so every delay
// line reads as zero at once, with no clearing pass over the history memory.
`default_nettype none

module multichannel_fir_highpass_unit (
   input  wire logic   clock,
   input  wire logic   reset,
   mcfir_req_if.sink   req_port,
   mcfir_rsp_if.source rsp_port
);

   mcfir_pkg::cmd_type    cmd;
   mcfir_pkg::status_type status;

   mcfir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mcfir_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_sample (req_port.sample_in),
      .req_chan   (req_port.chan_in),
      .rsp_ready  (rsp_port.ready),
      .rsp_valid  (rsp_port.valid),
      .rsp_sample (rsp_port.sample_out),
      .rsp_chan   (rsp_port.chan_out)
   );

endmodule

`default_nettype wire

### hdl/mcfir_chk.sv
// Port-level checker of the FIR unit and the bind that attaches it to the top level.
// Depends on mcfir_pkg for the field widths.
`default_nettype none

module mcfir_chk (
   input wire logic                                      clock,
   input wire logic                                      reset,
   input wire logic                                      req_valid,
   input wire logic                                      req_ready,
   input wire logic                                      rsp_valid,
   input wire logic                                      rsp_ready,
   input wire logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] rsp_sample,
   input wire logic [mcfir_pkg::CHAN_WIDTH-1:0]          rsp_chan
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("A result word was dropped before it was taken.");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sample) && $stable(rsp_chan))
      else $error("A stalled result word changed.");

   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("A second word was accepted while one was in work.");

   a_no_early_result : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##4 !$rose(rsp_valid))
      else $error("A result appeared before the taps could be summed.");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("A result word is shown right after reset.");

endmodule

bind multichannel_fir_highpass_unit mcfir_chk u_mcfir_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .rsp_sample (rsp_port.sample_out),
   .rsp_chan   (rsp_port.chan_out)
);

`default_nettype wire

### sim/mcfir_highpass_checker.sv
// Checker for the multichannel FIR high-pass unit: predicts every filtered word from the
// accepted sample words and compares it with what leaves the result channel.
// Depends on mcfir_pkg and the mcfir_req_if and mcfir_rsp_if interfaces.
`timescale 1ns / 1ps

module mcfir_highpass_checker (
   input  logic        clock,
   input  logic        reset,
   mcfir_req_if        req_mon,
   mcfir_rsp_if        rsp_mon,
   output int          mismatch_count,
   output int          pending_count
);

   localparam int REPORT_LIMIT = 10;

   // Left half of the symmetric high-pass response in Q1.15, center tap last.
   localparam int HP_WEIGHTS [mcfir_pkg::HALF_TAPS] = '{
      -309, 259, 207, 158, 80, -35, -174, -300,
      -368, -334, -176, 94, 427, 737, 919, 870,
      518, -158, -1115, -2244, -3388, -4374, -5040, 27492
   };

   typedef struct {
      logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] sample;
      logic [mcfir_pkg::CHAN_WIDTH-1:0]          chan;
   } filtered_word_type;

   logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] delay_line [mcfir_pkg::CHANNELS][mcfir_pkg::TAPS];
   filtered_word_type                         filtered_queue [$];

   function automatic logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] filter_sample(
      input logic [mcfir_pkg::CHAN_WIDTH-1:0]          chan,
      input logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] x
   );
      longint acc;
      longint y;
      longint limit_hi;
      longint limit_lo;
      int     idx;
      acc = 0;
      limit_hi = (longint'(1) <<< (mcfir_pkg::SAMPLE_WIDTH - 1)) - 1;
      limit_lo = -limit_hi - 1;
      if (int'(chan) >= mcfir_pkg::CHANNELS) begin
         return '0;
      end
      for (int k = 0; k < mcfir_pkg::TAPS; k++) begin
         idx = (k < mcfir_pkg::HALF_TAPS) ? k : mcfir_pkg::TAPS - 1 - k;
         acc += longint'(HP_WEIGHTS[idx] <<< (mcfir_pkg::COEF_WIDTH - 16)) *
                longint'(delay_line[chan][k]);
      end
      for (int k = 0; k < mcfir_pkg::TAPS - 1; k++) begin
         delay_line[chan][k] = delay_line[chan][k + 1];
      end
      delay_line[chan][mcfir_pkg::TAPS - 1] = x;
      y = (acc + (longint'(1) <<< (mcfir_pkg::COEF_WIDTH - 2))) >>> (mcfir_pkg::COEF_WIDTH - 1);
      if (y > limit_hi) begin
         y = limit_hi;
      end else if (y < limit_lo) begin
         y = limit_lo;
      end
      return mcfir_pkg::SAMPLE_WIDTH'(y);
   endfunction

   always @(posedge clock) begin
      filtered_word_type want;
      filtered_word_type seen;
      if (reset) begin
         foreach (delay_line[c, k]) begin
            delay_line[c][k] = '0;
         end
         filtered_queue.delete();
         mismatch_count = 0;
         pending_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.sample = rsp_mon.sample_out;
            seen.chan = rsp_mon.chan_out;
            if (filtered_queue.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: unexpected word, channel %0d sample %0d",
                           $realtime, seen.chan, seen.sample);
               end
            end else begin
               want = filtered_queue.pop_front();
               if (want.sample !== seen.sample || want.chan !== seen.chan) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: expected channel %0d sample %0d, got channel %0d sample %0d",
                              $realtime, want.chan, want.sample, seen.chan, seen.sample);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            want.chan = req_mon.chan_in;
            want.sample = filter_sample(req_mon.chan_in, req_mon.sample_in);
            filtered_queue.push_back(want);
         end
         pending_count = filtered_queue.size();
      end
   end

endmodule

### sim/multichannel_fir_highpass_unit_test.sv
// Top of the multichannel FIR high-pass testbench: clock, reset, sample stimulus and
// result back-pressure, with the verdict taken from mcfir_highpass_checker.
// Depends on mcfir_pkg, both channel interfaces, the unit and the checker.
`timescale 1ns / 1ps

module multichannel_fir_highpass_unit_test;

   localparam int WORD_COUNT      = 1550;
   localparam int HOLD_OFF_AFTER  = 200;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int DRAIN_CYCLES    = 64;

   typedef enum int {
      DRAIN_FREE,
      DRAIN_COIN,
      DRAIN_SLOW
   } drain_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   words_sent = 0;
   int   burst_left = 0;
   int   mismatch_count;
   int   pending_count;

   mcfir_req_if req_bus ();
   mcfir_rsp_if rsp_bus ();

   multichannel_fir_highpass_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   mcfir_highpass_checker monitor (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic send_word(input logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] value,
                            input logic [mcfir_pkg::CHAN_WIDTH-1:0] chan);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample_in <= value;
      req_bus.chan_in <= chan;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      words_sent++;
   endtask

   function automatic logic signed [mcfir_pkg::SAMPLE_WIDTH-1:0] pick_sample();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return raw[mcfir_pkg::SAMPLE_WIDTH-1:0];
      endcase
   endfunction

   // Fills one delay line with full-scale words whose signs follow the coefficients, so
   // the following word drives the filter into saturation.
   task automatic drive_saturating_run(input logic [mcfir_pkg::CHAN_WIDTH-1:0] chan,
                                       input bit negative);
      int idx;
      bit positive;
      for (int k = 0; k < mcfir_pkg::TAPS; k++) begin
         idx = (k < mcfir_pkg::HALF_TAPS) ? k : mcfir_pkg::TAPS - 1 - k;
         positive = (mcfir_pkg::COEF_Q15[idx] > 0) ^ negative;
         send_word(positive ? 16'sh7FFF : 16'sh8000, chan);
      end
      send_word(pick_sample(), chan);
   endtask

   initial begin
      int kind;
      req_bus.valid = 1'b0;
      req_bus.sample_in = '0;
      req_bus.chan_in = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_word(16'sh7FFF, 3'd0);
      send_word(16'sh8000, 3'd0);
      send_word(16'sh7FFF, 3'd0);
      send_word(16'sh0000, 3'd0);
      send_word(16'shFFFF, 3'd0);
      send_word(16'sh0001, 3'd0);
      send_word(16'sh8000, 3'd7);
      send_word(16'sh7FFF, 3'd7);
      send_word(16'sh5555, 3'd1);
      send_word(16'shAAAA, 3'd2);
      send_word(16'sh00FF, 3'd3);
      send_word(16'shFF00, 3'd4);
      send_word(16'sh7FFE, 3'd5);
      send_word(16'sh8001, 3'd6);
      send_word(16'sh8000, 3'd7);
      send_word(16'sh1234, 3'd1);
      send_word(16'shFFFF, 3'd0);
      send_word(16'sh0000, 3'd7);

      while (words_sent < WORD_COUNT) begin
         kind = $urandom_range(0, 199);
         if (kind < 2) begin
            drive_saturating_run(
               mcfir_pkg::CHAN_WIDTH'($urandom_range(0, mcfir_pkg::CHANNELS - 1)), kind == 1);
         end else begin
            send_word(pick_sample(),
                      mcfir_pkg::CHAN_WIDTH'($urandom_range(0, mcfir_pkg::CHANNELS - 1)));
         end
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("multichannel_fir_highpass_unit verification clean");
      end else begin
         $display("multichannel_fir_highpass_unit verification failed");
      end
      $finish;
   end

   initial begin
      drain_mode_type mode;
      int             mode_left;
      bit             held;
      rsp_bus.ready = 1'b0;
      mode = DRAIN_FREE;
      mode_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && words_sent >= HOLD_OFF_AFTER) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               case ($urandom_range(0, 2))
                  0: mode = DRAIN_FREE;
                  1: mode = DRAIN_COIN;
                  default: mode = DRAIN_SLOW;
               endcase
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
               DRAIN_FREE: rsp_bus.ready <= 1'b1;
               DRAIN_COIN: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      #10_000_000;
      $display("multichannel_fir_highpass_unit verification failed");
      $finish;
   end

endmodule
